/* hw/rtl/qsls_pkg.sv */
// ----------------------------------------------------------------------------
// qsls_pkg
// Types and codes shared by the quad spi lane shifter and its step logic.
// ----------------------------------------------------------------------------
package qsls_pkg;

    // command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_SELECT   = 3'd1;
    localparam logic [2:0] CMD_DESELECT = 3'd2;
    localparam logic [2:0] CMD_SEND_CMD = 3'd3;
    localparam logic [2:0] CMD_SEND_DAT = 3'd4;
    localparam logic [2:0] CMD_RECV_DAT = 3'd5;
    localparam logic [2:0] CMD_RECV_CMD = 3'd6;
    localparam logic [2:0] CMD_SPARE    = 3'd7;

    // bus modes
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_DUAL   = 2'd1;
    localparam logic [1:0] MODE_QUAD   = 2'd2;
    localparam logic [1:0] MODE_QPI    = 2'd3;

    // lane width codes
    localparam logic [1:0] LANE_ONE  = 2'd0;
    localparam logic [1:0] LANE_TWO  = 2'd1;
    localparam logic [1:0] LANE_FOUR = 2'd2;

    // pin setups
    localparam logic [3:0] IO_IDLE_DRIVE = 4'b1100;
    localparam logic [3:0] IO_EN_SINGLE  = 4'b1101;
    localparam logic [3:0] IO_EN_ALL     = 4'b1111;
    localparam logic [3:0] IO_EN_DUAL_RX = 4'b1100;
    localparam logic [3:0] IO_EN_NONE    = 4'b0000;
    localparam logic [7:0] RX_FILL_BYTE  = 8'hff;

    // register index of bus_mode
    localparam logic REG_BUS_MODE = 1'b0;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic [3:0] lines_in;
    } t_in_word;

    typedef struct packed {
        logic       clk_level;
        logic       chip_select_n;
        logic [3:0] lines_out;
        logic [3:0] lines_enable;
        logic       busy_res;
        logic       byte_done;
        logic [7:0] rx_byte;
        logic       rejected;
    } t_out_word;

    typedef struct packed {
        logic       chip_selected;
        logic [7:0] shift_out;
        logic [7:0] rx_accum;
        logic [2:0] beats_left;
        logic       high_phase;
        logic [1:0] lane_width;
        logic       receiving;
        logic [3:0] drive_lines;
        logic [3:0] enable_lines;
        logic       active;
    } t_shift_state;

    localparam t_shift_state STATE_RESET = '{
        chip_selected: 1'b0,
        shift_out:     8'h00,
        rx_accum:      8'h00,
        beats_left:    3'd0,
        high_phase:    1'b0,
        lane_width:    LANE_ONE,
        receiving:     1'b0,
        drive_lines:   IO_IDLE_DRIVE,
        enable_lines:  IO_EN_SINGLE,
        active:        1'b0
    };

endpackage

/* hw/rtl/qsls_step.sv */
// ----------------------------------------------------------------------------
// qsls_step
// One half serial-clock period: command decode, byte start and beat shifting.
// ----------------------------------------------------------------------------
module qsls_step
    import qsls_pkg::*;
(
    input  logic [1:0]   i_bus_mode,
    input  t_shift_state i_state,
    input  t_in_word     i_word,
    output t_shift_state o_state,
    output t_out_word    o_word
);

    logic [1:0]   data_lanes;
    logic [1:0]   cmd_lanes;
    logic [1:0]   start_lanes;
    logic         start_rx;
    logic         start;
    t_shift_state s;
    logic         clk;
    logic         busy;
    logic         done;
    logic         rej;
    logic [7:0]   rxo;

    // lane count for data and command bytes
    always_comb begin
        case (i_bus_mode)
            MODE_SINGLE: data_lanes = LANE_ONE;
            MODE_DUAL:   data_lanes = LANE_TWO;
            default:     data_lanes = LANE_FOUR;
        endcase
        cmd_lanes = (i_bus_mode == MODE_QPI) ? LANE_FOUR : LANE_ONE;
    end

    // command decode, then one half period of shifting
    always_comb begin
        s           = i_state;
        clk         = 1'b0;
        busy        = 1'b0;
        done        = 1'b0;
        rej         = 1'b0;
        rxo         = 8'h00;
        start       = 1'b0;
        start_rx    = 1'b0;
        start_lanes = LANE_ONE;

        if (i_state.active) begin
            rej = (i_word.command != CMD_TICK) && (i_word.command != CMD_SPARE);
        end else begin
            case (i_word.command)
                CMD_SELECT: begin
                    s.chip_selected = 1'b1;
                    s.drive_lines   = IO_IDLE_DRIVE;
                    s.enable_lines  = IO_EN_SINGLE;
                end
                CMD_DESELECT: begin
                    s.chip_selected = 1'b0;
                end
                CMD_SEND_CMD: begin
                    start       = 1'b1;
                    start_lanes = cmd_lanes;
                end
                CMD_SEND_DAT: begin
                    start       = 1'b1;
                    start_lanes = data_lanes;
                end
                CMD_RECV_DAT: begin
                    start       = 1'b1;
                    start_rx    = 1'b1;
                    start_lanes = data_lanes;
                end
                CMD_RECV_CMD: begin
                    start       = 1'b1;
                    start_rx    = 1'b1;
                    start_lanes = cmd_lanes;
                end
                default: begin
                end
            endcase
        end

        // byte start: lane setup and beat count
        if (start) begin
            s.lane_width = start_lanes;
            s.receiving  = start_rx;
            s.shift_out  = start_rx ? RX_FILL_BYTE : i_word.tx_byte;
            s.rx_accum   = 8'h00;
            s.high_phase = 1'b0;
            s.active     = 1'b1;
            case (start_lanes)
                LANE_ONE: begin
                    s.beats_left   = 3'd7;
                    s.enable_lines = IO_EN_SINGLE;
                end
                LANE_TWO: begin
                    s.beats_left   = 3'd3;
                    s.enable_lines = start_rx ? IO_EN_DUAL_RX : IO_EN_ALL;
                end
                default: begin
                    s.beats_left   = 3'd1;
                    s.enable_lines = start_rx ? IO_EN_NONE : IO_EN_ALL;
                end
            endcase
        end

        // clock-high half drives and samples, clock-low half counts beats
        if (s.active) begin
            busy = 1'b1;
            if (!s.high_phase) begin
                clk = 1'b1;
                case (s.lane_width)
                    LANE_ONE: begin
                        s.drive_lines = {2'b11, 1'b0, s.shift_out[7]};
                        s.rx_accum    = {s.rx_accum[6:0], i_word.lines_in[1]};
                        s.shift_out   = {s.shift_out[6:0], 1'b0};
                    end
                    LANE_TWO: begin
                        if (s.receiving) begin
                            s.drive_lines = IO_IDLE_DRIVE;
                            s.rx_accum    = {s.rx_accum[5:0], i_word.lines_in[1:0]};
                        end else begin
                            s.drive_lines = {2'b11, s.shift_out[7:6]};
                            s.shift_out   = {s.shift_out[5:0], 2'b00};
                        end
                    end
                    default: begin
                        if (s.receiving) begin
                            s.drive_lines = 4'b0000;
                            s.rx_accum    = {s.rx_accum[3:0], i_word.lines_in};
                        end else begin
                            s.drive_lines = s.shift_out[7:4];
                            s.shift_out   = {s.shift_out[3:0], 4'b0000};
                        end
                    end
                endcase
                s.high_phase = 1'b1;
            end else begin
                s.high_phase = 1'b0;
                if (s.beats_left == 3'd0) begin
                    s.active = 1'b0;
                    done     = 1'b1;
                    if ((s.lane_width == LANE_ONE) || s.receiving) begin
                        rxo = s.rx_accum;
                    end
                end else begin
                    s.beats_left = s.beats_left - 3'd1;
                end
            end
        end
    end

    assign o_state = s;

    // result word
    always_comb begin
        o_word.clk_level     = clk;
        o_word.chip_select_n = ~s.chip_selected;
        o_word.lines_out     = s.drive_lines & s.enable_lines;
        o_word.lines_enable  = s.enable_lines;
        o_word.busy_res      = busy;
        o_word.byte_done     = done;
        o_word.rx_byte       = rxo;
        o_word.rejected      = rej;
    end

endmodule

/* hw/rtl/quad_spi_lane_shifter.sv */
// The result word of an accepted input word is registered into the two-entry output buffer.
// Takes one word per cycle unless the full buffer stalls input; the shifter state updates in a single pass.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset (synchronous, active low) deselects the chip, stops any transfer,
// restores the single-lane pin setup, sets bus_mode to single and empties the buffer.
// ----------------------------------------------------------------------------
// quad_spi_lane_shifter
// SPI master byte shifter over 1, 2 or 4 io lanes, one word per half period.
// ----------------------------------------------------------------------------
module quad_spi_lane_shifter
    import qsls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]   r_bus_mode;
    t_shift_state r_state;
    t_shift_state n_state;
    t_out_word    n_word;
    t_out_word    r_out_head;
    t_out_word    r_out_tail;
    logic [1:0]   r_count;
    logic         in_acc;
    logic         out_acc;
    logic         cfg_wr;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BUS_MODE);
    assign prdata = (paddr[2] == REG_BUS_MODE) ? {30'd0, r_bus_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_mode <= MODE_SINGLE;
        end else if (cfg_wr) begin
            r_bus_mode <= pwdata[1:0];
        end
    end

    // handshakes
    assign o_in_stall  = (r_count == 2'd2);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != 2'd0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out_data  = r_out_head;

    // half period step
    qsls_step u_step (
        .i_bus_mode (r_bus_mode),
        .i_state    (r_state),
        .i_word     (i_in_data),
        .o_state    (n_state),
        .o_word     (n_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // two-entry result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (in_acc && !out_acc) begin
            r_count <= r_count + 2'd1;
        end else if (!in_acc && out_acc) begin
            r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && out_acc) begin
            if (r_count == 2'd1) begin
                r_out_head <= n_word;
            end else begin
                r_out_head <= r_out_tail;
                r_out_tail <= n_word;
            end
        end else if (in_acc) begin
            if (r_count == 2'd0) begin
                r_out_head <= n_word;
            end else begin
                r_out_tail <= n_word;
            end
        end else if (out_acc) begin
            r_out_head <= r_out_tail;
        end
    end

`ifndef NO_ASSERTIONS
    // buffer never overfills
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

    // a full buffer takes no input, so the count cannot wrap
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) && i_out_stall |=> (r_count == 2'd2))
        else $error("full buffer changed while stalled");

    // beat count of a running quad-lane byte fits its lane width
    a_beats_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.active && (r_state.lane_width == LANE_FOUR) |-> (r_state.beats_left <= 3'd1))
        else $error("quad byte with too many beats");

    // select while idle asserts chip select on the next cycle
    a_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_state.active && (i_in_data.command == CMD_SELECT)
        |=> r_state.chip_selected)
        else $error("select did not take effect");
`endif

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quad spi lane shifter. A queue of input words
// feeds a bursty driver; a monitor stalls the output on its own pattern and
// checks every result word against a cycle model of the shifter.
// ----------------------------------------------------------------------------
module tb_top
    import qsls_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_WORDS = 94;
    localparam int NUM_PHASES  = 8;
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quad_spi_lane_shifter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // shifter model state
    t_shift_state shifter = STATE_RESET;
    logic [1:0]   bus_mode_model = MODE_SINGLE;
    logic [1:0]   gen_mode = MODE_SINGLE;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        mismatches = 0;
    int        words_queued = 0;

    // load a byte transfer into the model
    function automatic void start_transfer(logic [1:0] lanes, logic rx, logic [7:0] data);
        shifter.lane_width = lanes;
        shifter.receiving  = rx;
        shifter.shift_out  = rx ? RX_FILL_BYTE : data;
        shifter.rx_accum   = '0;
        shifter.high_phase = 1'b0;
        shifter.active     = 1'b1;
        shifter.beats_left = 3'((4'd8 >> lanes) - 4'd1);
        case (lanes)
            LANE_ONE: shifter.enable_lines = IO_EN_SINGLE;
            LANE_TWO: shifter.enable_lines = rx ? IO_EN_DUAL_RX : IO_EN_ALL;
            default:  shifter.enable_lines = rx ? IO_EN_NONE : IO_EN_ALL;
        endcase
    endfunction

    // one half period of the serial clock
    function automatic t_out_word predict_half_period(t_in_word w);
        t_out_word  r;
        logic [1:0] data_lanes;
        logic [1:0] cmd_lanes;
        r = '0;
        data_lanes = (bus_mode_model == MODE_SINGLE) ? LANE_ONE :
                     (bus_mode_model == MODE_DUAL) ? LANE_TWO : LANE_FOUR;
        cmd_lanes = (bus_mode_model == MODE_QPI) ? LANE_FOUR : LANE_ONE;

        // operations are ignored during a transfer
        if (shifter.active) begin
            if (w.command != CMD_TICK && w.command != CMD_SPARE)
                r.rejected = 1'b1;
        end else begin
            case (w.command)
                CMD_SELECT: begin
                    shifter.chip_selected = 1'b1;
                    shifter.drive_lines   = IO_IDLE_DRIVE;
                    shifter.enable_lines  = IO_EN_SINGLE;
                end
                CMD_DESELECT: shifter.chip_selected = 1'b0;
                CMD_SEND_CMD: start_transfer(cmd_lanes, 1'b0, w.tx_byte);
                CMD_SEND_DAT: start_transfer(data_lanes, 1'b0, w.tx_byte);
                CMD_RECV_DAT: start_transfer(data_lanes, 1'b1, w.tx_byte);
                CMD_RECV_CMD: start_transfer(cmd_lanes, 1'b1, w.tx_byte);
                default: ;
            endcase
        end

        // beat progress: drive and sample on the high half
        if (shifter.active) begin
            r.busy_res = 1'b1;
            if (!shifter.high_phase) begin
                r.clk_level = 1'b1;
                case (shifter.lane_width)
                    LANE_ONE: begin
                        shifter.drive_lines = IO_IDLE_DRIVE | {3'b000, shifter.shift_out[7]};
                        shifter.rx_accum    = {shifter.rx_accum[6:0], w.lines_in[1]};
                        shifter.shift_out   = shifter.shift_out << 1;
                    end
                    LANE_TWO: begin
                        if (shifter.receiving) begin
                            shifter.drive_lines = IO_IDLE_DRIVE;
                            shifter.rx_accum    = {shifter.rx_accum[5:0], w.lines_in[1:0]};
                        end else begin
                            shifter.drive_lines = IO_IDLE_DRIVE | {2'b00, shifter.shift_out[7:6]};
                            shifter.shift_out   = shifter.shift_out << 2;
                        end
                    end
                    default: begin
                        if (shifter.receiving) begin
                            shifter.drive_lines = 4'b0000;
                            shifter.rx_accum    = {shifter.rx_accum[3:0], w.lines_in};
                        end else begin
                            shifter.drive_lines = shifter.shift_out[7:4];
                            shifter.shift_out   = shifter.shift_out << 4;
                        end
                    end
                endcase
                shifter.high_phase = 1'b1;
            end else begin
                shifter.high_phase = 1'b0;
                if (shifter.beats_left == 3'd0) begin
                    shifter.active = 1'b0;
                    r.byte_done = 1'b1;
                    if (shifter.lane_width == LANE_ONE || shifter.receiving)
                        r.rx_byte = shifter.rx_accum;
                end else begin
                    shifter.beats_left = shifter.beats_left - 3'd1;
                end
            end
        end

        r.chip_select_n = ~shifter.chip_selected;
        r.lines_out     = shifter.drive_lines & shifter.enable_lines;
        r.lines_enable  = shifter.enable_lines;
        return r;
    endfunction

    // word source with bursts and gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_words.push_back(predict_half_period(i_in_data));
            if (i_in_valid && o_in_stall) begin
                // stalled word stays as it is
            end else if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_words.size() > 0) begin
                i_in_data  <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result checking
    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    int   words_checked = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   stall_style = 0;
    int   style_left = 0;

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                words_checked++;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time,
                             o_out_data);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("clk_level", 8'(want.clk_level),
                                8'(o_out_data.clk_level));
                    check_field("chip_select_n", 8'(want.chip_select_n),
                                8'(o_out_data.chip_select_n));
                    check_field("lines_out", 8'(want.lines_out),
                                8'(o_out_data.lines_out));
                    check_field("lines_enable", 8'(want.lines_enable),
                                8'(o_out_data.lines_enable));
                    check_field("busy_res", 8'(want.busy_res),
                                8'(o_out_data.busy_res));
                    check_field("byte_done", 8'(want.byte_done),
                                8'(o_out_data.byte_done));
                    check_field("rx_byte", want.rx_byte, o_out_data.rx_byte);
                    check_field("rejected", 8'(want.rejected),
                                8'(o_out_data.rejected));
                end
            end

            // one long hold-off while words keep coming, else a changing stall style
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!hold_done && words_checked >= HOLD_AFTER && i_in_valid) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                if (style_left <= 0) begin
                    stall_style = $urandom_range(0, 3);
                    style_left = $urandom_range(10, 60);
                end
                style_left--;
                case (stall_style)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 9) < 3);
                    2:       i_out_stall <= (style_left % 3 == 0);
                    default: i_out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // watchdog on a stuck handshake
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("quad_spi_lane_shifter test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus helpers
    task automatic queue_word(logic [2:0] cmd, logic [7:0] tx, logic [3:0] lin);
        t_in_word w;
        w.command  = cmd;
        w.tx_byte  = tx;
        w.lines_in = lin;
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom());
        endcase
    endfunction

    // a byte op followed by filler words, mostly ticks, that usually cover its half periods
    task automatic queue_transfer(logic [2:0] op);
        int lanes;
        int fill;
        int r;
        if (op == CMD_SEND_CMD || op == CMD_RECV_CMD)
            lanes = (gen_mode == MODE_QPI) ? 4 : 1;
        else
            lanes = (gen_mode == MODE_SINGLE) ? 1 : (gen_mode == MODE_DUAL) ? 2 : 4;
        fill = 16 / lanes - 1;
        if ($urandom_range(0, 9) == 0)
            fill = $urandom_range(0, fill);
        queue_word(op, rand_byte(), 4'($urandom()));
        repeat (fill) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                queue_word(CMD_TICK, rand_byte(), 4'($urandom()));
            else if (r < 88)
                queue_word(CMD_SPARE, rand_byte(), 4'($urandom()));
            else
                queue_word(3'($urandom_range(CMD_SELECT, CMD_RECV_CMD)), rand_byte(),
                           4'($urandom()));
        end
    endtask

    task automatic write_bus_mode(logic [1:0] mode);
        logic [31:0] noise;
        noise = $urandom();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BUS_MODE, 2'b00};
        pwdata  <= {noise[31:2], mode};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bus_mode_model = mode;
        gen_mode = mode;
        @(negedge i_clk);
    endtask

    // sender pauses until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    initial begin
        int r;
        int target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: qpi, spare code, transfer while deselected, busy rejects
        write_bus_mode(MODE_QPI);
        queue_word(CMD_TICK, 8'h00, 4'hf);
        queue_word(CMD_SPARE, 8'hff, 4'h0);
        queue_word(CMD_DESELECT, 8'h00, 4'h0);
        queue_word(CMD_SEND_DAT, 8'hff, 4'h0);
        queue_word(CMD_RECV_CMD, 8'h00, 4'hf);
        queue_word(CMD_SPARE, 8'h5a, 4'h3);
        queue_word(CMD_SELECT, 8'h00, 4'h0);
        queue_word(CMD_RECV_DAT, 8'h00, 4'hf);
        queue_word(CMD_TICK, 8'h00, 4'h0);
        queue_word(CMD_TICK, 8'h00, 4'h0);
        queue_word(CMD_TICK, 8'h00, 4'ha);
        queue_word(CMD_SELECT, 8'h00, 4'h0);
        queue_word(CMD_SEND_CMD, 8'h00, 4'hf);
        queue_word(CMD_TICK, 8'hff, 4'h0);
        queue_word(CMD_DESELECT, 8'h00, 4'h0);
        queue_word(CMD_TICK, 8'h00, 4'h0);
        queue_word(CMD_RECV_CMD, 8'hff, 4'h5);
        queue_word(CMD_TICK, 8'h00, 4'h5);
        queue_word(CMD_TICK, 8'h00, 4'hc);
        queue_word(CMD_TICK, 8'h00, 4'h0);
        queue_word(CMD_DESELECT, 8'h00, 4'h0);
        wait_drained();

        // random phases, all modes in turn then random modes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_bus_mode((ph < 4) ? 2'(ph) : 2'($urandom_range(MODE_SINGLE, MODE_QPI)));
            target = words_queued + PHASE_WORDS;
            while (words_queued < target) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    queue_word(CMD_SELECT, rand_byte(), 4'($urandom()));
                else if (r < 12)
                    queue_word(CMD_DESELECT, rand_byte(), 4'($urandom()));
                else if (r < 16)
                    queue_word(CMD_TICK, rand_byte(), 4'($urandom()));
                else if (r < 18)
                    queue_word(CMD_SPARE, rand_byte(), 4'($urandom()));
                else
                    queue_transfer(3'($urandom_range(CMD_SEND_CMD, CMD_RECV_CMD)));
            end
            wait_drained();
        end

        repeat (5) @(negedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("quad_spi_lane_shifter test passed");
        else
            $display("quad_spi_lane_shifter test failed");
        $finish;
    end

endmodule
